// File: rtl/core/spq_pkg.sv
// Package for the sorted priority queue: field widths, operation codes and
// the entry and control structs shared by the cells and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 8;
  localparam int OCC_W        = 5;
  localparam int DEF_CAPACITY = 16;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [PRIO_W-1:0]         prio_t;
  typedef logic [OCC_W-1:0]          occ_t;

  localparam value_t VALUE_UNDERFLOW = -32'sd1;
  localparam value_t VALUE_NONE      = 32'sd0;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    value_t value;
    prio_t  prio;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t fresh;
  } cell_ctl_t;

endpackage

// File: rtl/core/spq_if.sv
// Valid/ready channel interfaces for the input and result transfers of the
// sorted priority queue. Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_in_if import spq_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  op;
  value_t value_in;
  prio_t prio_in;

  modport source (output valid, output op, output value_in, output prio_in, input ready);
  modport sink (input valid, input op, input value_in, input prio_in, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value_out;
  logic   underflow;
  logic   overflow;
  logic   is_empty;
  occ_t   occupancy;

  modport source (output valid, output value_out, output underflow, output overflow,
                  output is_empty, output occupancy, input ready);
  modport sink (input valid, input value_out, input underflow, input overflow,
                input is_empty, input occupancy, output ready);
endinterface

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds a value and its priority, compares the
// incoming priority and takes the new entry or a neighbor's entry. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_stay,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      stay,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // An occupied slot whose priority is at least the new one stays ahead of it.
  assign stay  = occupied && (entry_r.prio >= ctl.fresh.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq && !stay) begin
      entry_nxt = left_stay ? ctl.fresh : left_entry;
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of CAPACITY slot cells, the
// entry count and the result register. Depends on spq_pkg, spq_if and spq_cell.
//
//   Channel | Direction | Carries
//   in_ch   | sink      | op, value_in, prio_in
//   out_ch  | source    | value_out, underflow, overflow, is_empty, occupancy
//
// All slots compare and shift in parallel.
// The result of a transfer appears in the result register in the next cycle.
// A new input transfer is taken whenever the result register is empty or is
// being emptied in the same cycle, so the rate is one item per cycle.
// Reset clears the count and the result valid flag; slot contents need none.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  value_t           value_out_r;
  logic             underflow_r;
  logic             overflow_r;
  logic             is_empty_r;
  occ_t             occupancy_r;

  logic      in_xfer;
  logic      is_deq;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;

  entry_t    entries [CAPACITY];
  logic      stays   [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_deq      = (in_ch.op == OP_DEQ);
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);

  assign ctl.enq         = in_xfer && !is_deq && !full;
  assign ctl.deq         = in_xfer && is_deq && !empty;
  assign ctl.fresh.value = in_ch.value_in;
  assign ctl.fresh.prio  = in_ch.prio_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

    logic   occupied;
    logic   left_stay;
    entry_t left_entry;

    assign occupied   = (CNT_W'(i) < count_r);
    assign left_stay  = (i == 0) ? 1'b1 : stays[LEFT];
    assign left_entry = (i == 0) ? ctl.fresh : entries[LEFT];

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occupied),
      .left_stay   (left_stay),
      .left_entry  (left_entry),
      .right_entry (entries[RIGHT]),
      .stay        (stays[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (is_deq) begin
        value_out_r <= empty ? VALUE_UNDERFLOW : entries[0].value;
      end else begin
        value_out_r <= VALUE_NONE;
      end
      underflow_r <= is_deq && empty;
      overflow_r  <= !is_deq && full;
      is_empty_r  <= (count_nxt == '0);
      occupancy_r <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = value_out_r;
  assign out_ch.underflow = underflow_r;
  assign out_ch.overflow  = overflow_r;
  assign out_ch.is_empty  = is_empty_r;
  assign out_ch.occupancy = occupancy_r;

endmodule

// File: tb/tb.sv
// Self-checking testbench for sorted_priority_queue: drives enqueue and dequeue transfers with
// random gaps and stalls, and checks every result against a queue kept in step with the block.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int SLOTS        = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PCT     = 21;

  typedef struct {
    value_t value;
    logic   underflow;
    logic   overflow;
    logic   is_empty;
    occ_t   occupancy;
  } outcome_t;

  class priority_shadow;
    entry_t   held[$];
    outcome_t pending[$];
    int       mismatches = 0;
    int       enq_count = 0;
    int       deq_count = 0;
    int       underflows = 0;
    int       overflows = 0;
    int       peak = 0;

    task report_mismatch(string msg);
      if (mismatches < 25) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_request(op_t op, value_t v, prio_t p);
      outcome_t o;
      entry_t   e;
      int       k;
      o.value     = VALUE_NONE;
      o.underflow = 1'b0;
      o.overflow  = 1'b0;
      if (op == OP_ENQ) begin
        enq_count++;
        if (held.size() >= SLOTS) begin
          o.overflow = 1'b1;
          overflows++;
        end else begin
          k = 0;
          while (k < held.size() && held[k].prio >= p) k++;
          e.value = v;
          e.prio  = p;
          held.insert(k, e);
        end
      end else begin
        deq_count++;
        if (held.size() == 0) begin
          o.value     = VALUE_UNDERFLOW;
          o.underflow = 1'b1;
          underflows++;
        end else begin
          o.value = held[0].value;
          held.delete(0);
        end
      end
      o.is_empty  = (held.size() == 0);
      o.occupancy = occ_t'(held.size());
      if (held.size() > peak) peak = held.size();
      pending.push_back(o);
    endfunction

    task check_response(value_t v, logic u, logic ov, logic e, occ_t n);
      outcome_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (value %0d)", v));
      end else begin
        want = pending.pop_front();
        if (v !== want.value)
          report_mismatch($sformatf("value_out %0d, expected %0d", v, want.value));
        if (u !== want.underflow)
          report_mismatch($sformatf("underflow %b, expected %b", u, want.underflow));
        if (ov !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b", ov, want.overflow));
        if (e !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, expected %b", e, want.is_empty));
        if (n !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", n, want.occupancy));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  priority_shadow shadow;

  sorted_priority_queue #(.CAPACITY(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_item(op_t op, value_t v, prio_t p);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.value_in <= v;
    in_ch.prio_in  <= p;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_request(op, v, p);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        shadow.check_response(out_ch.value_out, out_ch.underflow, out_ch.overflow,
                              out_ch.is_empty, out_ch.occupancy);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #3000000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

  initial begin
    prio_t  fill_prio [16];
    value_t v;
    prio_t  p;
    op_t    op;
    int     lean;
    int     tie_bias;
    shadow = new;
    fill_prio = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h01, 8'hFE, 8'hFF,
                  8'h00, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'h80, 8'hFF, 8'h00};
    calm = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_ENQ;
    in_ch.value_in <= VALUE_NONE;
    in_ch.prio_in  <= '0;
    rst_n          <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: underflow on empty, a full fill with ties and extremes, overflow, four dequeues.
    send_item(OP_DEQ, 32'sh1234_5678, 8'hAA);
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = -32'sd1;
        3: v = 32'sd0;
        default: v = value_t'(32'h5A5A_0000 + i);
      endcase
      send_item(OP_ENQ, v, fill_prio[i]);
    end
    send_item(OP_ENQ, 32'sd42, 8'hFF);
    repeat (4) send_item(OP_DEQ, 32'sd0, 8'h00);

    lean = 50;
    tie_bias = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: lean = 80;
          1: lean = 20;
          default: lean = 50;
        endcase
        tie_bias = $urandom_range(1);
      end
      calm = (n >= 160 && n < 260);
      op = ($urandom_range(99) < lean) ? OP_ENQ : OP_DEQ;
      v  = pick_value();
      case ($urandom_range(7))
        0: p = 8'h00;
        1: p = 8'hFF;
        2, 3, 4: p = tie_bias ? prio_t'($urandom_range(3)) : prio_t'($urandom_range(255));
        default: p = prio_t'($urandom_range(255));
      endcase
      send_item(op, v, p);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d enqueues and %0d dequeues, %0d underflows and %0d overflows.",
             shadow.enq_count, shadow.deq_count, shadow.underflows, shadow.overflows);
    $display("Peak occupancy %0d of %0d slots, %0d mismatches.",
             shadow.peak, SLOTS, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/tb.sv
